// ===== src/oximeter_record_drop_detector_assert.svh =====
// Assertion macros shared by the drop detector RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef OXIMETER_RECORD_DROP_DETECTOR_ASSERT_SVH
`define OXIMETER_RECORD_DROP_DETECTOR_ASSERT_SVH

// Condition implies consequence in the same cycle
`define ORDD_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ordd assertion failed");

// Condition implies consequence in the following cycle
`define ORDD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ordd assertion failed");

`endif

// ===== src/ordd_pkg.sv =====
// Shared constants, types and helpers of the oximeter record drop detector.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ordd_pkg;

	// Default sizes
	localparam int unsigned HISTORY_DEPTH_DEF = 16;
	localparam int unsigned LENGTH_BITS_DEF   = 24;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PULSE_W = 7;
	localparam int unsigned SPO2_W  = 8;
	localparam int unsigned INDEX_W = 24;
	localparam int unsigned WIN_W   = 5;
	localparam int unsigned PLIM_W  = 7;
	localparam int unsigned SLIM_W  = 8;
	localparam int unsigned APB_AW  = 4;
	localparam int unsigned APB_DW  = 32;

	// Stream framing bytes
	localparam logic [BYTE_W-1:0] HDR0      = 8'hF2;
	localparam logic [BYTE_W-1:0] HDR1      = 8'h80;
	localparam logic [BYTE_W-1:0] HDR2      = 8'h00;
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hF0;
	localparam logic [2:0]        HDR_LAST  = 3'd2;
	localparam logic [2:0]        SKIP_LAST = 3'd5;

	// Register reset values
	localparam logic [WIN_W-1:0]  PULSE_WIN_RST = 5'd4;
	localparam logic [WIN_W-1:0]  SPO2_WIN_RST  = 5'd10;
	localparam logic [PLIM_W-1:0] PULSE_LIM_RST = 7'd6;
	localparam logic [SLIM_W-1:0] SPO2_LIM_RST  = 8'd4;

	// Result kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_FAULT  = 1'b1;

	// Register map, word index
	typedef enum logic [1:0] {
		REG_PULSE_WIN,
		REG_SPO2_WIN,
		REG_PULSE_LIM,
		REG_SPO2_LIM
	} reg_idx_t;

	// Parser event for the accepted byte
	typedef struct packed {
		logic               rec;
		logic               fault;
		logic [INDEX_W-1:0] index;
		logic [PULSE_W-1:0] pulse;
		logic [SPO2_W-1:0]  spo2;
		logic               is_last;
	} evt_t;

	// One result word
	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] record_index;
		logic [PULSE_W-1:0] pulse;
		logic [SPO2_W-1:0]  spo2;
		logic               pulse_changed;
		logic               spo2_changed;
		logic               pulse_drop_flag;
		logic [PULSE_W-1:0] pulse_drop;
		logic               spo2_drop_flag;
		logic [SPO2_W-1:0]  spo2_drop;
		logic               is_last;
	} res_t;

	// Expected header byte at a match position
	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] pos);
		logic [BYTE_W-1:0] b;
		unique case (pos)
			2'd0:    b = HDR0;
			2'd1:    b = HDR1;
			default: b = HDR2;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/oximeter_record_drop_detector.sv =====
// A result word is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one byte per cycle; in_stall rises only while the skid stage is
// occupied, i.e. while two finished words wait behind a stalled output.
// History spread: a chain of min/max prefix cells, one per sample, updated per record.
// Reset (arst_n low): header search, all counters, history and registers to defaults.
// No clearing pass: the block takes bytes as soon as reset is released.
`default_nettype none

module oximeter_record_drop_detector #(
	parameter int unsigned HISTORY_DEPTH = ordd_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned LENGTH_BITS   = ordd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ordd_pkg::APB_AW-1:0]  paddr,
	input  wire logic [ordd_pkg::APB_DW-1:0]  pwdata,
	output logic      [ordd_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	// byte input
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ordd_pkg::BYTE_W-1:0]  data_byte,
	// result output
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              kind,
	output logic      [ordd_pkg::INDEX_W-1:0] record_index,
	output logic      [ordd_pkg::PULSE_W-1:0] pulse,
	output logic      [ordd_pkg::SPO2_W-1:0]  spo2,
	output logic                              pulse_changed,
	output logic                              spo2_changed,
	output logic                              pulse_drop_flag,
	output logic      [ordd_pkg::PULSE_W-1:0] pulse_drop,
	output logic                              spo2_drop_flag,
	output logic      [ordd_pkg::SPO2_W-1:0]  spo2_drop,
	output logic                              is_last
);

	localparam int unsigned IW = $clog2(HISTORY_DEPTH);
	localparam int unsigned PW = ordd_pkg::PULSE_W;
	localparam int unsigned SW = ordd_pkg::SPO2_W;

	logic [ordd_pkg::WIN_W-1:0]  pulse_window_q;
	logic [ordd_pkg::WIN_W-1:0]  spo2_window_q;
	logic [ordd_pkg::PLIM_W-1:0] pulse_drop_limit_q;
	logic [ordd_pkg::SLIM_W-1:0] spo2_drop_limit_q;
	logic [PW-1:0]               prev_pulse_q;
	logic [SW-1:0]               prev_spo2_q;

	logic            accept;
	logic            cfg_wr;
	logic            full;
	logic            push;
	ordd_pkg::evt_t  evt;
	ordd_pkg::res_t  res;
	ordd_pkg::res_t  out_data;

	logic [PW-1:0] p_min [HISTORY_DEPTH];
	logic [PW-1:0] p_max [HISTORY_DEPTH];
	logic [SW-1:0] s_min [HISTORY_DEPTH];
	logic [SW-1:0] s_max [HISTORY_DEPTH];

	logic [IW-1:0] sel_p, sel_s, sel_p_m1, sel_s_m1;
	logic [PW-1:0] win_p_min, win_p_max, win_p_spread;
	logic [SW-1:0] win_s_min, win_s_max, win_s_spread;

	assign accept = in_valid && !in_stall;
	assign in_stall = full;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_window_q     <= ordd_pkg::PULSE_WIN_RST;
			spo2_window_q      <= ordd_pkg::SPO2_WIN_RST;
			pulse_drop_limit_q <= ordd_pkg::PULSE_LIM_RST;
			spo2_drop_limit_q  <= ordd_pkg::SPO2_LIM_RST;
		end else if (cfg_wr) begin
			unique case (ordd_pkg::reg_idx_t'(paddr[3:2]))
				ordd_pkg::REG_PULSE_WIN: pulse_window_q <= pwdata[ordd_pkg::WIN_W-1:0];
				ordd_pkg::REG_SPO2_WIN:  spo2_window_q  <= pwdata[ordd_pkg::WIN_W-1:0];
				ordd_pkg::REG_PULSE_LIM: pulse_drop_limit_q <= pwdata[ordd_pkg::PLIM_W-1:0];
				ordd_pkg::REG_SPO2_LIM:  spo2_drop_limit_q  <= pwdata[ordd_pkg::SLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (ordd_pkg::reg_idx_t'(paddr[3:2]))
			ordd_pkg::REG_PULSE_WIN: prdata = ordd_pkg::APB_DW'(pulse_window_q);
			ordd_pkg::REG_SPO2_WIN:  prdata = ordd_pkg::APB_DW'(spo2_window_q);
			ordd_pkg::REG_PULSE_LIM: prdata = ordd_pkg::APB_DW'(pulse_drop_limit_q);
			ordd_pkg::REG_SPO2_LIM:  prdata = ordd_pkg::APB_DW'(spo2_drop_limit_q);
			default:                 prdata = '0;
		endcase
	end

	// Byte parser
	ordd_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.evt       (evt)
	);

	// History chain: cell k holds min/max of the newest k+1 samples
	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			ordd_cell #(.W(PW)) u_pcell (
				.clk(clk), .arst_n(arst_n), .shift(evt.rec), .new_val(evt.pulse),
				.prev_min(evt.pulse), .prev_max(evt.pulse),
				.cur_min(p_min[k]), .cur_max(p_max[k])
			);
			ordd_cell #(.W(SW)) u_scell (
				.clk(clk), .arst_n(arst_n), .shift(evt.rec), .new_val(evt.spo2),
				.prev_min(evt.spo2), .prev_max(evt.spo2),
				.cur_min(s_min[k]), .cur_max(s_max[k])
			);
		end else begin : g_body
			ordd_cell #(.W(PW)) u_pcell (
				.clk(clk), .arst_n(arst_n), .shift(evt.rec), .new_val(evt.pulse),
				.prev_min(p_min[k-1]), .prev_max(p_max[k-1]),
				.cur_min(p_min[k]), .cur_max(p_max[k])
			);
			ordd_cell #(.W(SW)) u_scell (
				.clk(clk), .arst_n(arst_n), .shift(evt.rec), .new_val(evt.spo2),
				.prev_min(s_min[k-1]), .prev_max(s_max[k-1]),
				.cur_min(s_min[k]), .cur_max(s_max[k])
			);
		end
	end

	// Clamp windows to one cell place
	always_comb begin
		if (pulse_window_q == '0) begin
			sel_p = '0;
		end else if (32'(pulse_window_q) > 32'(HISTORY_DEPTH)) begin
			sel_p = IW'(HISTORY_DEPTH - 1);
		end else begin
			sel_p = IW'(pulse_window_q - 1'b1);
		end
		if (spo2_window_q == '0) begin
			sel_s = '0;
		end else if (32'(spo2_window_q) > 32'(HISTORY_DEPTH)) begin
			sel_s = IW'(HISTORY_DEPTH - 1);
		end else begin
			sel_s = IW'(spo2_window_q - 1'b1);
		end
	end

	assign sel_p_m1 = sel_p - 1'b1;
	assign sel_s_m1 = sel_s - 1'b1;

	// Window min/max: new sample folded into the older prefix
	always_comb begin
		win_p_min = evt.pulse;
		win_p_max = evt.pulse;
		win_s_min = evt.spo2;
		win_s_max = evt.spo2;
		if (sel_p != '0) begin
			if (p_min[sel_p_m1] < evt.pulse) win_p_min = p_min[sel_p_m1];
			if (p_max[sel_p_m1] > evt.pulse) win_p_max = p_max[sel_p_m1];
		end
		if (sel_s != '0) begin
			if (s_min[sel_s_m1] < evt.spo2) win_s_min = s_min[sel_s_m1];
			if (s_max[sel_s_m1] > evt.spo2) win_s_max = s_max[sel_s_m1];
		end
	end

	assign win_p_spread = win_p_max - win_p_min;
	assign win_s_spread = win_s_max - win_s_min;

	// Assemble the result word
	always_comb begin
		res = '0;
		res.record_index = evt.index;
		res.is_last      = evt.is_last;
		if (evt.fault) begin
			res.kind = ordd_pkg::KIND_FAULT;
		end else begin
			res.kind            = ordd_pkg::KIND_RECORD;
			res.pulse           = evt.pulse;
			res.spo2            = evt.spo2;
			res.pulse_changed   = (evt.pulse != prev_pulse_q);
			res.spo2_changed    = (evt.spo2 != prev_spo2_q);
			res.pulse_drop      = win_p_spread;
			res.spo2_drop       = win_s_spread;
			res.pulse_drop_flag = (win_p_min != '0) && (win_p_max != '0) &&
				(win_p_spread > pulse_drop_limit_q);
			res.spo2_drop_flag  = (win_s_min != '0) && (win_s_max != '0) &&
				(win_s_spread > spo2_drop_limit_q);
		end
	end

	// Hold the previous record values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pulse_q <= '0;
			prev_spo2_q  <= '0;
		end else if (evt.rec) begin
			prev_pulse_q <= evt.pulse;
			prev_spo2_q  <= evt.spo2;
		end
	end

	assign push = evt.rec || evt.fault;

	// Output register and skid
	ordd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind            = out_data.kind;
	assign record_index    = out_data.record_index;
	assign pulse           = out_data.pulse;
	assign spo2            = out_data.spo2;
	assign pulse_changed   = out_data.pulse_changed;
	assign spo2_changed    = out_data.spo2_changed;
	assign pulse_drop_flag = out_data.pulse_drop_flag;
	assign pulse_drop      = out_data.pulse_drop;
	assign spo2_drop_flag  = out_data.spo2_drop_flag;
	assign spo2_drop       = out_data.spo2_drop;
	assign is_last         = out_data.is_last;

endmodule

`default_nettype wire

// ===== src/ordd_cell.sv =====
// One history cell: running min and max of the newest samples up to this place.
// Depends on ordd_pkg for the default width.
`default_nettype none

module ordd_cell #(
	parameter int unsigned W = ordd_pkg::PULSE_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic [W-1:0] new_val,
	input  wire logic [W-1:0] prev_min,
	input  wire logic [W-1:0] prev_max,
	output logic      [W-1:0] cur_min,
	output logic      [W-1:0] cur_max
);

	logic [W-1:0] min_q;
	logic [W-1:0] max_q;

	// Fold the new sample into the neighbour's prefix and take it over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (shift) begin
			min_q <= (prev_min < new_val) ? prev_min : new_val;
			max_q <= (prev_max > new_val) ? prev_max : new_val;
		end
	end

	assign cur_min = min_q;
	assign cur_max = max_q;

endmodule

`default_nettype wire

// ===== src/ordd_parse.sv =====
// Byte parser: header hunt, skip, length gathering and record framing.
// Depends on ordd_pkg and the assertion macro header.
`default_nettype none

`include "oximeter_record_drop_detector_assert.svh"

module ordd_parse #(
	parameter int unsigned LENGTH_BITS = ordd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [ordd_pkg::BYTE_W-1:0] data_byte,
	output ordd_pkg::evt_t                   evt
);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_LENGTH,
		PH_RECORD
	} phase_t;

	typedef enum logic [1:0] {
		POS_SYNC,
		POS_PULSE,
		POS_SPO2
	} pos_t;

	localparam logic [LENGTH_BITS-1:0] LEN_SHIFT_MAX = {LENGTH_BITS{1'b1}} >> 7;

	phase_t                            phase_q, phase_d;
	pos_t                              pos_q, pos_d;
	logic [2:0]                        count_q, count_d;
	logic [LENGTH_BITS-1:0]            len_q, len_d;
	logic [LENGTH_BITS-1:0]            seen_q, seen_d, seen_inc;
	logic [ordd_pkg::PULSE_W-1:0]      pend_q, pend_d;
	logic [ordd_pkg::INDEX_W-1:0]      counter_q, counter_d;

	// Saturating byte count of the record stream
	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 1'b1;

	// Next state and event for the accepted byte
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		count_d   = count_q;
		len_d     = len_q;
		seen_d    = seen_q;
		pend_d    = pend_q;
		counter_d = counter_q;
		evt       = '0;
		if (accept) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (data_byte == ordd_pkg::hdr_byte(count_q[1:0])) begin
						if (count_q == ordd_pkg::HDR_LAST) begin
							phase_d = PH_SKIP;
							count_d = '0;
						end else begin
							count_d = count_q + 1'b1;
						end
					end else begin
						count_d = (data_byte == ordd_pkg::HDR0) ? 3'd1 : 3'd0;
					end
				end
				PH_SKIP: begin
					if (count_q == ordd_pkg::SKIP_LAST) begin
						phase_d = PH_LENGTH;
						count_d = '0;
						len_d   = '0;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
				PH_LENGTH: begin
					if (data_byte != ordd_pkg::SYNC_BYTE) begin
						len_d = (len_q > LEN_SHIFT_MAX) ? '1 :
							{len_q[LENGTH_BITS-8:0], data_byte[6:0]};
					end else begin
						// this sync byte opens the first record
						phase_d = PH_RECORD;
						pos_d   = POS_PULSE;
						seen_d  = LENGTH_BITS'(1);
					end
				end
				PH_RECORD: begin
					seen_d = seen_inc;
					unique case (pos_q)
						POS_SYNC: begin
							if (data_byte == ordd_pkg::SYNC_BYTE) begin
								pos_d = POS_PULSE;
							end else begin
								evt.fault   = 1'b1;
								evt.index   = counter_q;
								evt.is_last = (seen_inc >= len_q);
							end
						end
						POS_PULSE: begin
							pend_d = data_byte[6:0];
							pos_d  = POS_SPO2;
						end
						default: begin
							evt.rec     = 1'b1;
							evt.index   = counter_q;
							evt.pulse   = pend_q;
							evt.spo2    = data_byte;
							evt.is_last = (seen_inc >= len_q);
							pos_d       = POS_SYNC;
							counter_d   = (counter_q == '1) ? counter_q :
								counter_q + 1'b1;
						end
					endcase
				end
				default: phase_d = PH_SEARCH;
			endcase
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEARCH;
			pos_q     <= POS_SYNC;
			count_q   <= '0;
			len_q     <= '0;
			seen_q    <= '0;
			pend_q    <= '0;
			counter_q <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			count_q   <= count_d;
			len_q     <= len_d;
			seen_q    <= seen_d;
			pend_q    <= pend_d;
			counter_q <= counter_d;
		end
	end

	`ORDD_ASSERT_SAME(a_evt_in_record, clk, arst_n, evt.rec || evt.fault, phase_q == PH_RECORD)
	`ORDD_ASSERT_SAME(a_search_count, clk, arst_n, phase_q == PH_SEARCH, count_q <= ordd_pkg::HDR_LAST)
	`ORDD_ASSERT_NEXT(a_rec_resync, clk, arst_n, evt.rec, pos_q == POS_SYNC && phase_q == PH_RECORD)

endmodule

`default_nettype wire

// ===== src/ordd_obuf.sv =====
// Output register with a skid stage between the result path and the output port.
// Depends on ordd_pkg and the assertion macro header.
`default_nettype none

`include "oximeter_record_drop_detector_assert.svh"

module ordd_obuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  ordd_pkg::res_t      push_data,
	output logic                full,
	output logic                out_valid,
	input  wire logic           out_stall,
	output ordd_pkg::res_t      out_data
);

	logic           out_valid_q;
	logic           skid_valid_q;
	ordd_pkg::res_t out_q;
	ordd_pkg::res_t skid_q;
	logic           adv;

	// Output slot frees when empty or taken
	assign adv = !out_valid_q || !out_stall;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload words
	always_ff @(posedge clk) begin
		if (adv) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ORDD_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ORDD_ASSERT_SAME(a_push_has_room, clk, arst_n, push, !skid_valid_q)

endmodule

`default_nettype wire

// ===== bench/ordd_record_checker.sv =====
// Checker for the oximeter record drop detector bench: predicts every result word.
// Depends on ordd_pkg; watches the register port, the byte input and the result output.
`default_nettype none

module ordd_record_checker
	import ordd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic              kind,
	input  wire logic [INDEX_W-1:0] record_index,
	input  wire logic [PULSE_W-1:0] pulse,
	input  wire logic [SPO2_W-1:0] spo2,
	input  wire logic              pulse_changed,
	input  wire logic              spo2_changed,
	input  wire logic              pulse_drop_flag,
	input  wire logic [PULSE_W-1:0] pulse_drop,
	input  wire logic              spo2_drop_flag,
	input  wire logic [SPO2_W-1:0] spo2_drop,
	input  wire logic              is_last,
	output int unsigned            fail_count,
	output int unsigned            words_waiting,
	output int unsigned            records_seen,
	output int unsigned            faults_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned        HIST      = 16;
	localparam logic [23:0]        LEN_MAX   = 24'hFF_FFFF;
	localparam logic [23:0]        INDEX_MAX = 24'hFF_FFFF;
	localparam logic [23:0]        HEADER    = {HDR0, HDR1, HDR2};
	localparam int unsigned        SKIP_LEN  = 6;

	typedef enum logic [1:0] {
		HUNT,
		SKIP_FIELDS,
		GATHER_LEN,
		RECORDS
	} parse_phase_t;

	// Register copies
	logic [WIN_W-1:0]   pulse_win;
	logic [WIN_W-1:0]   spo2_win;
	logic [PLIM_W-1:0]  pulse_lim;
	logic [SLIM_W-1:0]  spo2_lim;

	// Parser and history state
	parse_phase_t       phase;
	logic [2:0]         step_cnt;
	logic [23:0]        announced;
	logic [23:0]        bytes_seen;
	logic [1:0]         rec_pos;
	logic [PULSE_W-1:0] held_pulse;
	logic [PULSE_W-1:0] last_pulse;
	logic [SPO2_W-1:0]  last_spo2;
	logic [23:0]        rec_cnt;
	logic [PULSE_W-1:0] pulse_hist [HIST];
	logic [SPO2_W-1:0]  spo2_hist [HIST];
	logic [3:0]         hist_ptr;

	res_t               expected_words [$];

	// Print one line per failure and count it
	task automatic note_failure(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string what, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want)
			note_failure($sformatf("field %s got %0h, expected %0h", what, got, want));
	endtask

	// Append a predicted word behind the ones already waiting
	task automatic queue_word(input res_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	// Max minus min over the newest samples; window 0 acts as 1, above depth as depth
	function automatic logic [7:0] window_spread(input bit of_spo2,
			input logic [WIN_W-1:0] w_cfg, output bit both_nz);
		int unsigned span;
		int unsigned idx;
		logic [7:0]  v;
		logic [7:0]  lo;
		logic [7:0]  hi;
		span = (w_cfg == 0) ? 1 : ((w_cfg > HIST) ? HIST : w_cfg);
		idx = 32'(hist_ptr);
		lo = 8'hFF;
		hi = 8'h00;
		for (int k = 0; k < span; k++) begin
			v = of_spo2 ? spo2_hist[idx] : {1'b0, pulse_hist[idx]};
			if (v < lo) lo = v;
			if (v > hi) hi = v;
			idx = (idx == 0) ? HIST - 1 : idx - 1;
		end
		both_nz = (lo != 0) && (hi != 0);
		return hi - lo;
	endfunction

	// Advance the parser by one byte; returns 1 when the byte yields a word
	function automatic bit decode_byte(input logic [7:0] b, output res_t w);
		logic [7:0] want;
		logic [7:0] pd;
		logic [7:0] sd;
		bit         pnz;
		bit         snz;
		w = '0;
		if (phase == HUNT) begin
			want = HEADER[8 * (2 - int'(step_cnt)) +: 8];
			if (b == want) begin
				step_cnt++;
				if (step_cnt == 3) begin
					phase = SKIP_FIELDS;
					step_cnt = '0;
				end
			end else begin
				step_cnt = (b == HDR0) ? 3'd1 : 3'd0;
			end
			return 1'b0;
		end
		if (phase == SKIP_FIELDS) begin
			step_cnt++;
			if (step_cnt == SKIP_LEN) begin
				phase = GATHER_LEN;
				step_cnt = '0;
				announced = '0;
			end
			return 1'b0;
		end
		if (phase == GATHER_LEN) begin
			if (b != SYNC_BYTE) begin
				if (announced > (LEN_MAX >> 7))
					announced = LEN_MAX;
				else
					announced = (announced << 7) | {17'd0, b[6:0]};
				return 1'b0;
			end
			// the closing sync byte opens the first record
			phase = RECORDS;
			rec_pos = 2'd0;
			bytes_seen = '0;
		end

		if (bytes_seen != LEN_MAX) bytes_seen++;

		// Record start: sync byte or a fault word
		if (rec_pos == 0) begin
			if (b == SYNC_BYTE) begin
				rec_pos = 2'd1;
				return 1'b0;
			end
			w.kind = KIND_FAULT;
			w.record_index = rec_cnt;
			w.is_last = (bytes_seen >= announced);
			return 1'b1;
		end
		if (rec_pos == 1) begin
			held_pulse = b[6:0];
			rec_pos = 2'd2;
			return 1'b0;
		end

		// Saturation byte completes the record
		rec_pos = 2'd0;
		pulse_hist[hist_ptr] = held_pulse;
		spo2_hist[hist_ptr] = b;
		pd = window_spread(1'b0, pulse_win, pnz);
		sd = window_spread(1'b1, spo2_win, snz);
		w.kind = KIND_RECORD;
		w.record_index = rec_cnt;
		w.pulse = held_pulse;
		w.spo2 = b;
		w.pulse_changed = (held_pulse != last_pulse);
		w.spo2_changed = (b != last_spo2);
		w.pulse_drop_flag = pnz && (pd > pulse_lim);
		w.pulse_drop = pd[6:0];
		w.spo2_drop_flag = snz && (sd > spo2_lim);
		w.spo2_drop = sd;
		w.is_last = (bytes_seen >= announced);
		last_pulse = held_pulse;
		last_spo2 = b;
		hist_ptr++;
		if (rec_cnt != INDEX_MAX) rec_cnt++;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		res_t fresh;
		if (!arst_n) begin
			pulse_win = PULSE_WIN_RST;
			spo2_win = SPO2_WIN_RST;
			pulse_lim = PULSE_LIM_RST;
			spo2_lim = SPO2_LIM_RST;
			phase = HUNT;
			step_cnt = '0;
			announced = '0;
			bytes_seen = '0;
			rec_pos = '0;
			held_pulse = '0;
			last_pulse = '0;
			last_spo2 = '0;
			rec_cnt = '0;
			hist_ptr = '0;
			for (int k = 0; k < HIST; k++) begin
				pulse_hist[k] = '0;
				spo2_hist[k] = '0;
			end
			expected_words.delete();
			fail_count = 0;
			words_waiting = 0;
			records_seen = 0;
			faults_seen = 0;
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_PULSE_WIN: pulse_win = pwdata[WIN_W-1:0];
					REG_SPO2_WIN:  spo2_win = pwdata[WIN_W-1:0];
					REG_PULSE_LIM: pulse_lim = pwdata[PLIM_W-1:0];
					REG_SPO2_LIM:  spo2_lim = pwdata[SLIM_W-1:0];
				endcase
			end

			// Check the word leaving the block against the oldest prediction
			if (out_valid && !out_stall) begin
				got = {kind, record_index, pulse, spo2, pulse_changed, spo2_changed,
					pulse_drop_flag, pulse_drop, spo2_drop_flag, spo2_drop, is_last};
				if (got.kind === KIND_FAULT) faults_seen++;
				else records_seen++;
				if (expected_words.size() == 0) begin
					note_failure($sformatf("word with index %0h arrived with none expected",
						got.record_index));
				end else begin
					want = expected_words.pop_front();
					compare_field("kind", got.kind, want.kind);
					compare_field("record_index", got.record_index, want.record_index);
					compare_field("pulse", got.pulse, want.pulse);
					compare_field("spo2", got.spo2, want.spo2);
					compare_field("pulse_changed", got.pulse_changed, want.pulse_changed);
					compare_field("spo2_changed", got.spo2_changed, want.spo2_changed);
					compare_field("pulse_drop_flag", got.pulse_drop_flag, want.pulse_drop_flag);
					compare_field("pulse_drop", got.pulse_drop, want.pulse_drop);
					compare_field("spo2_drop_flag", got.spo2_drop_flag, want.spo2_drop_flag);
					compare_field("spo2_drop", got.spo2_drop, want.spo2_drop);
					compare_field("is_last", got.is_last, want.is_last);
				end
			end

			// Predict from the byte taken in
			if (in_valid && !in_stall) begin
				if (decode_byte(data_byte, fresh))
					queue_word(fresh);
			end
			words_waiting = expected_words.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/oximeter_record_drop_detector_tb.sv =====
// Top of the oximeter record drop detector bench: clock, reset, byte stimulus and verdict.
// Depends on ordd_pkg, the block itself and ordd_record_checker, which predicts and compares.
`default_nettype none

module oximeter_record_drop_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ordd_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned DRAIN_LIMIT  = 5000;
	localparam time         RUN_LIMIT    = 2_000_000ns;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [BYTE_W-1:0]   data_byte;
	logic                out_valid;
	logic                out_stall;
	logic                kind;
	logic [INDEX_W-1:0]  record_index;
	logic [PULSE_W-1:0]  pulse;
	logic [SPO2_W-1:0]   spo2;
	logic                pulse_changed;
	logic                spo2_changed;
	logic                pulse_drop_flag;
	logic [PULSE_W-1:0]  pulse_drop;
	logic                spo2_drop_flag;
	logic [SPO2_W-1:0]   spo2_drop;
	logic                is_last;

	int unsigned         fail_count;
	int unsigned         words_waiting;
	int unsigned         records_seen;
	int unsigned         faults_seen;

	int unsigned         idle_pct = 0;
	int unsigned         stall_pct = 0;
	bit                  hold_req = 1'b0;
	int unsigned         bytes_sent = 0;
	int unsigned         pulse_base = 70;
	int unsigned         spo2_base = 95;

	oximeter_record_drop_detector uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.record_index    (record_index),
		.pulse           (pulse),
		.spo2            (spo2),
		.pulse_changed   (pulse_changed),
		.spo2_changed    (spo2_changed),
		.pulse_drop_flag (pulse_drop_flag),
		.pulse_drop      (pulse_drop),
		.spo2_drop_flag  (spo2_drop_flag),
		.spo2_drop       (spo2_drop),
		.is_last         (is_last)
	);

	ordd_record_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.record_index    (record_index),
		.pulse           (pulse),
		.spo2            (spo2),
		.pulse_changed   (pulse_changed),
		.spo2_changed    (spo2_changed),
		.pulse_drop_flag (pulse_drop_flag),
		.pulse_drop      (pulse_drop),
		.spo2_drop_flag  (spo2_drop_flag),
		.spo2_drop       (spo2_drop),
		.is_last         (is_last),
		.fail_count      (fail_count),
		.words_waiting   (words_waiting),
		.records_seen    (records_seen),
		.faults_seen     (faults_seen)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#RUN_LIMIT;
		$display("run timed out with %0d words outstanding", words_waiting);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random stall, or a long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one byte, idling first at random; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_record(input logic [7:0] p, input logic [7:0] s);
		send_byte(SYNC_BYTE);
		send_byte(p);
		send_byte(s);
	endtask

	// Register write: setup cycle, then access cycle until pready, then idle with psel low
	task automatic write_reg(input reg_idx_t r, input logic [7:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 2'b00};
		pwdata <= {16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] pw, input logic [7:0] sw,
			input logic [7:0] pl, input logic [7:0] sl);
		write_reg(REG_PULSE_WIN, pw);
		write_reg(REG_SPO2_WIN, sw);
		write_reg(REG_PULSE_LIM, pl);
		write_reg(REG_SPO2_LIM, sl);
	endtask

	// Hold the input until every predicted word has come out, then let the block settle
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Pulse byte: mostly jitter round a drifting base, some zeros and wild values
	function automatic logic [7:0] next_pulse_byte();
		int unsigned roll;
		logic [6:0]  v;
		logic        top;
		roll = $urandom_range(99);
		top = 1'($urandom_range(1));
		if (roll < 5) pulse_base = $urandom_range(110, 30);
		if (roll >= 5 && roll < 13) v = '0;
		else if (roll >= 13 && roll < 21) v = 7'($urandom_range(127));
		else v = 7'(pulse_base + $urandom_range(8) - 4);
		return {top, v};
	endfunction

	function automatic logic [7:0] next_spo2_byte();
		int unsigned roll;
		logic [7:0]  v;
		roll = $urandom_range(99);
		if (roll < 5) spo2_base = $urandom_range(99, 80);
		if (roll >= 5 && roll < 13) v = '0;
		else if (roll >= 13 && roll < 21) v = 8'($urandom_range(255));
		else v = 8'(spo2_base + $urandom_range(6) - 3);
		return v;
	endfunction

	// Mostly clean records, with fault bytes, cut-short records and stray bytes mixed in
	task automatic random_traffic(input int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned roll;
		logic [7:0]  b;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 78) begin
				send_record(next_pulse_byte(), next_spo2_byte());
			end else if (roll < 88) begin
				repeat ($urandom_range(3, 1)) begin
					b = 8'($urandom_range(255));
					if (b == SYNC_BYTE) b = ~SYNC_BYTE;
					send_byte(b);
				end
			end else if (roll < 94) begin
				// record cut short: the next sync byte lands in the saturation slot
				send_byte(SYNC_BYTE);
				send_byte(next_pulse_byte());
				send_record(next_pulse_byte(), next_spo2_byte());
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Header hunt with broken matches, two restarting on F2 itself
		send_byte(HDR0); send_byte(HDR0); send_byte(HDR1); send_byte(8'h01);
		send_byte(HDR0); send_byte(HDR1); send_byte(HDR0); send_byte(HDR1);
		send_byte(HDR2);
		// Six skipped bytes that look like framing
		send_byte(SYNC_BYTE); send_byte(HDR0); send_byte(HDR1); send_byte(HDR2);
		send_byte(8'hFF); send_byte(8'h55);
		// Length: usually ends mid-run so the last flag turns on; sometimes saturates
		if ($urandom_range(3) == 0) begin
			send_byte(8'h7F); send_byte(8'hFF); send_byte(8'h7F); send_byte(8'h7F);
		end else begin
			send_byte(8'h00); send_byte(8'h84); send_byte(8'h40);
		end
		// Closing sync byte doubles as the first record's sync
		send_byte(SYNC_BYTE); send_byte(8'hFF); send_byte(8'hFF);
		send_record(8'h00, 8'h00);
		send_byte(8'h00); send_byte(8'hFF);
		send_record(8'h80, 8'hFF);
		send_record(SYNC_BYTE, SYNC_BYTE);
		settle();

		// Narrowest and widest windows, zero limits, no idling, long hold-off first
		set_config(8'd1, 8'd16, 8'd0, 8'd0);
		hold_req = 1'b1;
		random_traffic(300);
		settle();

		// Swap windows, top limits, sender mostly idle
		set_config(8'd16, 8'd1, 8'd127, 8'd255);
		idle_pct = 78;
		random_traffic(300);
		settle();

		// Out-of-range windows, small limits, receiver mostly stalled
		set_config(8'd0, 8'd17, 8'd3, 8'd2);
		idle_pct = 0;
		stall_pct = 78;
		random_traffic(300);
		settle();

		// All-ones and zero windows, both sides idling now and then, pause midway
		set_config(8'd31, 8'd0, 8'd10, 8'd5);
		idle_pct = 20;
		stall_pct = 20;
		random_traffic(150);
		settle();
		random_traffic(150);

		// Drain
		in_valid <= 1'b0;
		@(negedge clk);
		for (int k = 0; k < DRAIN_LIMIT && words_waiting != 0; k++) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("%0d bytes sent through header hunt, length and record decoding", bytes_sent);
		$display("%0d records and %0d sync faults checked over five register settings",
			records_seen, faults_seen);
		if (fail_count == 0 && words_waiting == 0) begin
			$display("RESULT: OK");
		end else begin
			if (words_waiting != 0)
				$display("%0d predicted words never came out", words_waiting);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
